### sv/input_edge_state_tracker_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the input edge-state tracker.
// Implication checks sampled on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef INPUT_EDGE_STATE_TRACKER_CORE_ASSERT_SVH
`define INPUT_EDGE_STATE_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication.
`define IEST_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("input edge-state tracker check failed");

// Next-cycle implication.
`define IEST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("input edge-state tracker check failed");

`endif

### sv/iest_pkg.sv
// ----------------------------------------------------------------------------
// iest_pkg
// Shared types and defaults for the input edge-state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package iest_pkg;

  localparam int KEY_SLOTS_DEF        = 256;
  localparam int BUTTON_SLOTS_DEF     = 8;
  localparam int CHAR_FIFO_DEPTH_DEF  = 16;
  localparam int PRESS_FIFO_DEPTH_DEF = 16;

  typedef enum logic [3:0] {
    ACT_KEYPRESS   = 4'd0,
    ACT_KEYRELEASE = 4'd1,
    ACT_CHAR       = 4'd2,
    ACT_BTNPRESS   = 4'd3,
    ACT_BTNRELEASE = 4'd4,
    ACT_MOTION     = 4'd5,
    ACT_FRAMETICK  = 4'd6,
    ACT_QUERY      = 4'd7,
    ACT_POPCHAR    = 4'd8,
    ACT_POPBTN     = 4'd9,
    ACT_CLEARKEYS  = 4'd10,
    ACT_CLEARMOUSE = 4'd11
  } action_t;

  typedef struct packed {
    action_t            act;
    logic               key_ok;
    logic               btn_ok;
    logic [7:0]         key_code;
    logic [2:0]         button_num;
    logic               repeat_flag;
    logic [20:0]        char_code;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [15:0] delta_z;
    logic signed [31:0] wheel_abs;
  } item_t;

  typedef struct packed {
    logic sweeping;
    logic executing;
  } back_status_t;

endpackage

`default_nettype wire

### sv/iest_front.sv
// ----------------------------------------------------------------------------
// iest_front
// Accepts requests, decodes the action and checks the slot indices.
// ----------------------------------------------------------------------------
`default_nettype none

module iest_front import iest_pkg::*; #(
  parameter int KEY_SLOTS    = KEY_SLOTS_DEF,
  parameter int BUTTON_SLOTS = BUTTON_SLOTS_DEF
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic [7:0]         key_code,
  input  logic [2:0]         button_num,
  input  logic               repeat_flag,
  input  logic [20:0]        char_code,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [15:0] delta_z,
  input  logic signed [31:0] wheel_abs,
  input  logic               q_full,
  output logic               q_push,
  output item_t              q_item
);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item = '0;
    priority if (action > ACT_CLEARMOUSE) begin
      q_item.act = ACT_QUERY;
    end else begin
      q_item.act = action_t'(action);
    end
    q_item.key_ok      = (key_code != 8'd0) && (11'(key_code) < 11'(KEY_SLOTS));
    q_item.btn_ok      = (button_num != 3'd0) && (6'(button_num) < 6'(BUTTON_SLOTS));
    q_item.key_code    = key_code;
    q_item.button_num  = button_num;
    q_item.repeat_flag = repeat_flag;
    q_item.char_code   = char_code;
    q_item.delta_x     = delta_x;
    q_item.delta_y     = delta_y;
    q_item.delta_z     = delta_z;
    q_item.wheel_abs   = wheel_abs;
  end

endmodule

`default_nettype wire

### sv/iest_queue.sv
// ----------------------------------------------------------------------------
// iest_queue
// Two-entry queue of decoded requests between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module iest_queue import iest_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full       = (cnt == 2'd2);
  assign head_valid = (cnt != 2'd0);
  assign head_item  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

### sv/iest_back.sv
// ----------------------------------------------------------------------------
// iest_back
// Carries out decoded requests: key and button slots, the two FIFOs,
// motion accumulation and the key slot sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module iest_back import iest_pkg::*; #(
  parameter int KEY_SLOTS        = KEY_SLOTS_DEF,
  parameter int BUTTON_SLOTS     = BUTTON_SLOTS_DEF,
  parameter int CHAR_FIFO_DEPTH  = CHAR_FIFO_DEPTH_DEF,
  parameter int PRESS_FIFO_DEPTH = PRESS_FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  item_t              q_item,
  output logic               q_pop,
  output back_status_t       status,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               key_is_down,
  output logic               key_pressed,
  output logic               key_released,
  output logic               button_is_down,
  output logic               button_pressed,
  output logic               button_released,
  output logic [20:0]        popped_value,
  output logic signed [31:0] move_x,
  output logic signed [31:0] move_y,
  output logic signed [31:0] move_z,
  output logic signed [31:0] wheel_pos
);

  localparam int KW  = $clog2(KEY_SLOTS);
  localparam int BW  = $clog2(BUTTON_SLOTS);
  localparam int CIW = (CHAR_FIFO_DEPTH > 1) ? $clog2(CHAR_FIFO_DEPTH) : 1;
  localparam int PIW = (PRESS_FIFO_DEPTH > 1) ? $clog2(PRESS_FIFO_DEPTH) : 1;
  localparam int CCW = $clog2(CHAR_FIFO_DEPTH + 1);
  localparam int PCW = $clog2(PRESS_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_SWEEP = 3'b100
  } state_t;

  state_t      state;
  item_t       cur;
  logic [KW-1:0] sweep_idx;
  logic        sweep_clr_down;
  logic [1:0]  ignore_flags;

  logic        key_down_mem [KEY_SLOTS];
  logic        key_chg_mem  [KEY_SLOTS];
  logic        rd_down;
  logic        rd_chg;

  logic [BUTTON_SLOTS-1:0] btn_down;
  logic [BUTTON_SLOTS-1:0] btn_chg;

  logic [20:0]    char_mem [CHAR_FIFO_DEPTH];
  logic [CIW-1:0] char_head;
  logic [CCW-1:0] char_count;
  logic [20:0]    rd_char;
  logic [2:0]     press_mem [PRESS_FIFO_DEPTH];
  logic [PIW-1:0] press_head;
  logic [PCW-1:0] press_count;
  logic [2:0]     rd_press;

  logic signed [31:0] mx, my, mz, wheel_reg;

  logic [KW+7:0] q_kext, c_kext;
  logic [KW-1:0] q_kaddr, c_kaddr;
  logic [BW+2:0] c_bext;
  logic [BW-1:0] c_bidx;

  logic exec_go;
  logic kevt, want_k, ktog, kd, kc;
  logic bevt, want_b, bcur_d, bcur_c, btog, bd, bc;
  logic kd_we, kc_we, kd_wdata, kc_wdata;
  logic [KW-1:0] kw_addr;

  logic           char_push, char_pop, press_push, press_pop;
  logic [CIW:0]   char_sum;
  logic [CIW-1:0] char_tail;
  logic [PIW:0]   press_sum;
  logic [PIW-1:0] press_tail;
  logic [20:0]    popped;
  logic signed [31:0] mx_next, my_next, mz_next, wheel_next;

  assign q_kext  = (KW + 8)'(q_item.key_code);
  assign q_kaddr = q_kext[KW-1:0];
  assign c_kext  = (KW + 8)'(cur.key_code);
  assign c_kaddr = c_kext[KW-1:0];
  assign c_bext  = (BW + 3)'(cur.button_num);
  assign c_bidx  = c_bext[BW-1:0];

  assign q_pop   = (state == ST_IDLE) && q_valid;
  assign exec_go = (state == ST_EXEC) && (!out_valid || !out_stall);
  assign status.sweeping  = (state == ST_SWEEP);
  assign status.executing = (state == ST_EXEC);

  always_comb begin
    want_k = (cur.act == ACT_KEYPRESS);
    kevt   = ((cur.act == ACT_KEYPRESS) || (cur.act == ACT_KEYRELEASE)) &&
             !ignore_flags[0] && cur.key_ok;
    ktog   = kevt && (rd_down != want_k);
    kd     = ktog ? want_k : rd_down;
    kc     = ktog ? 1'b1 : rd_chg;
    if (cur.act == ACT_FRAMETICK) begin
      kc = 1'b0;
    end
    if (cur.act == ACT_CLEARKEYS) begin
      kd = 1'b0;
      kc = 1'b0;
    end
    if (!cur.key_ok) begin
      kd = 1'b0;
      kc = 1'b0;
    end

    want_b = (cur.act == ACT_BTNPRESS);
    bevt   = ((cur.act == ACT_BTNPRESS) || (cur.act == ACT_BTNRELEASE)) &&
             !ignore_flags[1] && cur.btn_ok;
    bcur_d = btn_down[c_bidx];
    bcur_c = btn_chg[c_bidx];
    btog   = bevt && (bcur_d != want_b);
    bd     = btog ? want_b : bcur_d;
    bc     = btog ? 1'b1 : bcur_c;
    if (cur.act == ACT_FRAMETICK) begin
      bc = 1'b0;
    end
    if (cur.act == ACT_CLEARMOUSE) begin
      bd = 1'b0;
      bc = 1'b0;
    end
    if (!cur.btn_ok) begin
      bd = 1'b0;
      bc = 1'b0;
    end
  end

  always_comb begin
    if (state == ST_SWEEP) begin
      kw_addr  = sweep_idx;
      kd_we    = sweep_clr_down;
      kc_we    = 1'b1;
      kd_wdata = 1'b0;
      kc_wdata = 1'b0;
    end else begin
      kw_addr  = c_kaddr;
      kd_we    = exec_go && ktog;
      kc_we    = exec_go && ktog;
      kd_wdata = want_k;
      kc_wdata = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kd_we) begin
      key_down_mem[kw_addr] <= kd_wdata;
    end
    if (kc_we) begin
      key_chg_mem[kw_addr] <= kc_wdata;
    end
    if (q_pop) begin
      rd_down <= key_down_mem[q_kaddr];
      rd_chg  <= key_chg_mem[q_kaddr];
    end
  end

  always_comb begin
    char_push  = exec_go && (cur.act == ACT_CHAR) && !ignore_flags[0] &&
                 !cur.repeat_flag && (char_count < CCW'(CHAR_FIFO_DEPTH));
    char_pop   = exec_go && (cur.act == ACT_POPCHAR) && (char_count != '0);
    press_push = exec_go && bevt && want_b &&
                 (press_count < PCW'(PRESS_FIFO_DEPTH));
    press_pop  = exec_go && (cur.act == ACT_POPBTN) && (press_count != '0);
    char_sum   = {1'b0, char_head} + (CIW + 1)'(char_count);
    if (char_sum >= (CIW + 1)'(CHAR_FIFO_DEPTH)) begin
      char_sum = char_sum - (CIW + 1)'(CHAR_FIFO_DEPTH);
    end
    char_tail  = char_sum[CIW-1:0];
    press_sum  = {1'b0, press_head} + (PIW + 1)'(press_count);
    if (press_sum >= (PIW + 1)'(PRESS_FIFO_DEPTH)) begin
      press_sum = press_sum - (PIW + 1)'(PRESS_FIFO_DEPTH);
    end
    press_tail = press_sum[PIW-1:0];
    popped = '0;
    if (char_pop) begin
      popped = rd_char;
    end
    if (press_pop) begin
      popped = 21'(rd_press);
    end
  end

  always_ff @(posedge clk) begin
    if (char_push) begin
      char_mem[char_tail] <= cur.char_code;
    end
    if (press_push) begin
      press_mem[press_tail] <= cur.button_num;
    end
    if (q_pop) begin
      rd_char  <= char_mem[char_head];
      rd_press <= press_mem[press_head];
    end
  end

  always_comb begin
    mx_next    = mx;
    my_next    = my;
    mz_next    = mz;
    wheel_next = wheel_reg;
    if (cur.act == ACT_MOTION) begin
      mx_next    = mx + {{16{cur.delta_x[15]}}, cur.delta_x};
      my_next    = my + {{16{cur.delta_y[15]}}, cur.delta_y};
      mz_next    = mz + {{16{cur.delta_z[15]}}, cur.delta_z};
      wheel_next = cur.wheel_abs;
    end
    if (cur.act == ACT_FRAMETICK) begin
      mx_next = '0;
      my_next = '0;
      mz_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
    if (exec_go) begin
      key_is_down     <= kd;
      key_pressed     <= kd && kc;
      key_released    <= !kd && kc;
      button_is_down  <= bd;
      button_pressed  <= bd && bc;
      button_released <= !bd && bc;
      popped_value    <= popped;
      move_x          <= mx_next;
      move_y          <= my_next;
      move_z          <= mz_next;
      wheel_pos       <= wheel_next;
    end
    if (rst) begin
      state          <= ST_SWEEP;
      sweep_idx      <= '0;
      sweep_clr_down <= 1'b1;
      ignore_flags   <= 2'b00;
      btn_down       <= '0;
      btn_chg        <= '0;
      char_head      <= '0;
      char_count     <= '0;
      press_head     <= '0;
      press_count    <= '0;
      mx             <= '0;
      my             <= '0;
      mz             <= '0;
      wheel_reg      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !exec_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            out_valid <= 1'b1;
            mx        <= mx_next;
            my        <= my_next;
            mz        <= mz_next;
            wheel_reg <= wheel_next;
            if (btog) begin
              btn_down[c_bidx] <= want_b;
              btn_chg[c_bidx]  <= 1'b1;
            end
            if (char_push) begin
              char_count <= char_count + 1'b1;
            end
            if (char_pop) begin
              char_head  <= (char_head == CIW'(CHAR_FIFO_DEPTH - 1)) ? '0 :
                            char_head + 1'b1;
              char_count <= char_count - 1'b1;
            end
            if (press_push) begin
              press_count <= press_count + 1'b1;
            end
            if (press_pop) begin
              press_head  <= (press_head == PIW'(PRESS_FIFO_DEPTH - 1)) ? '0 :
                             press_head + 1'b1;
              press_count <= press_count - 1'b1;
            end
            unique case (cur.act)
              ACT_FRAMETICK: begin
                btn_chg        <= '0;
                ignore_flags   <= 2'b00;
                sweep_idx      <= '0;
                sweep_clr_down <= 1'b0;
                state          <= ST_SWEEP;
              end
              ACT_CLEARKEYS: begin
                char_head       <= '0;
                char_count      <= '0;
                ignore_flags[0] <= 1'b1;
                sweep_idx       <= '0;
                sweep_clr_down  <= 1'b1;
                state           <= ST_SWEEP;
              end
              ACT_CLEARMOUSE: begin
                btn_down        <= '0;
                btn_chg         <= '0;
                press_head      <= '0;
                press_count     <= '0;
                ignore_flags[1] <= 1'b1;
                state           <= ST_IDLE;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (sweep_idx == KW'(KEY_SLOTS - 1)) begin
            state <= ST_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/input_edge_state_tracker_core.sv
// ----------------------------------------------------------------------------
// input_edge_state_tracker_core
// Edge-state latch for keys and mouse buttons with per-frame clearing,
// character and button-press FIFOs and motion accumulation.
//
//   Channel   Handshake            Payload
//   input     in_valid / in_stall  action, key_code, button_num, repeat_flag,
//                                  char_code, delta_x, delta_y, delta_z,
//                                  wheel_abs
//   output    out_valid/out_stall  key and button flags, popped_value,
//                                  move_x, move_y, move_z, wheel_pos
//
// In the execution unit a request is taken from the queue while the key slot
// and FIFO memories are read; it then updates state and loads the result
// register once that register is empty or not stalled. A frame tick or key
// clear then sweeps all KEY_SLOTS entries of the key slot memory, one entry a
// cycle. After reset a clearing pass over the key slots runs; up to two requests
// are queued meanwhile. A stalled result holds the execution unit; the queue
// then fills and stalls the input.
// ----------------------------------------------------------------------------
`default_nettype none

`include "input_edge_state_tracker_core_assert.svh"

module input_edge_state_tracker_core import iest_pkg::*; #(
  parameter int KEY_SLOTS        = KEY_SLOTS_DEF,
  parameter int BUTTON_SLOTS     = BUTTON_SLOTS_DEF,
  parameter int CHAR_FIFO_DEPTH  = CHAR_FIFO_DEPTH_DEF,
  parameter int PRESS_FIFO_DEPTH = PRESS_FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         action,
  input  logic [7:0]         key_code,
  input  logic [2:0]         button_num,
  input  logic               repeat_flag,
  input  logic [20:0]        char_code,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [15:0] delta_z,
  input  logic signed [31:0] wheel_abs,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               key_is_down,
  output logic               key_pressed,
  output logic               key_released,
  output logic               button_is_down,
  output logic               button_pressed,
  output logic               button_released,
  output logic [20:0]        popped_value,
  output logic signed [31:0] move_x,
  output logic signed [31:0] move_y,
  output logic signed [31:0] move_z,
  output logic signed [31:0] wheel_pos
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  item_t        push_item;
  item_t        head_item;
  back_status_t st;

  iest_front #(
    .KEY_SLOTS    (KEY_SLOTS),
    .BUTTON_SLOTS (BUTTON_SLOTS)
  ) u_front (
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .action      (action),
    .key_code    (key_code),
    .button_num  (button_num),
    .repeat_flag (repeat_flag),
    .char_code   (char_code),
    .delta_x     (delta_x),
    .delta_y     (delta_y),
    .delta_z     (delta_z),
    .wheel_abs   (wheel_abs),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  iest_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (head_item)
  );

  iest_back #(
    .KEY_SLOTS        (KEY_SLOTS),
    .BUTTON_SLOTS     (BUTTON_SLOTS),
    .CHAR_FIFO_DEPTH  (CHAR_FIFO_DEPTH),
    .PRESS_FIFO_DEPTH (PRESS_FIFO_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_valid         (q_valid),
    .q_item          (head_item),
    .q_pop           (q_pop),
    .status          (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .key_is_down     (key_is_down),
    .key_pressed     (key_pressed),
    .key_released    (key_released),
    .button_is_down  (button_is_down),
    .button_pressed  (button_pressed),
    .button_released (button_released),
    .popped_value    (popped_value),
    .move_x          (move_x),
    .move_y          (move_y),
    .move_z          (move_z),
    .wheel_pos       (wheel_pos)
  );

  `IEST_ASSERT_IMPL(a_no_take_in_sweep, st.sweeping, !q_pop)
  `IEST_ASSERT_NEXT(a_take_then_exec, q_pop, st.executing && !q_pop)
  `IEST_ASSERT_IMPL(a_reset_starts_sweep, $fell(rst), st.sweeping)

endmodule

`default_nettype wire
